### hdl/hckd_pkg.sv
// ----------------------------------------------------------------------------
// hckd_pkg
// Shared types, constants and SHA-512 helper functions for the hardened
// child key derivation block.
// ----------------------------------------------------------------------------
`default_nettype none
package hckd_pkg;

  localparam logic [255:0] ORDER =
    256'hFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFEBAAEDCE6AF48A03BBFD25E8CD0364141;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOT_HRD = 2'd1;
  localparam logic [1:0] ST_IL_BIG  = 2'd2;
  localparam logic [1:0] ST_ZERO    = 2'd3;

  localparam logic [511:0] SHA_IV = {
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
    64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;      // capture inputs
    logic blk_start; // load message block and chaining words
    logic [1:0] blk; // which block: 0 ipad, 1 inner msg, 2 opad, 3 outer msg
    logic round;     // run one round
    logic finish;    // add working state into chaining value
    logic reduce;    // compute child key and status
  } hckd_cmd_t;

  typedef struct packed {
    logic last_round;
  } hckd_sts_t;

  function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

  function automatic logic [63:0] round_k(input logic [6:0] i);
    logic [63:0] k;
    case (i)
      7'd0: k = 64'h428a2f98d728ae22;  7'd1: k = 64'h7137449123ef65cd;
      7'd2: k = 64'hb5c0fbcfec4d3b2f;  7'd3: k = 64'he9b5dba58189dbbc;
      7'd4: k = 64'h3956c25bf348b538;  7'd5: k = 64'h59f111f1b605d019;
      7'd6: k = 64'h923f82a4af194f9b;  7'd7: k = 64'hab1c5ed5da6d8118;
      7'd8: k = 64'hd807aa98a3030242;  7'd9: k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
      default: k = 64'h0;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

### hdl/hckd_ctrl.sv
// ----------------------------------------------------------------------------
// hckd_ctrl
// Sequencer: four SHA-512 compressions of 80 rounds, then the key reduction.
// ----------------------------------------------------------------------------
`default_nettype none
module hckd_ctrl import hckd_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire logic      hardened,
  input  wire hckd_sts_t sts,
  output hckd_cmd_t      cmd,
  output logic           busy,
  output logic           done,
  output logic           skip
);

  typedef enum logic [2:0] {S_IDLE, S_BLK, S_RND, S_FIN, S_RED} state_t;

  state_t state;
  logic [1:0] blk;

  // Command decode
  always_comb begin
    cmd = '0;
    cmd.load      = start && !busy;
    cmd.blk       = blk;
    cmd.blk_start = (state == S_BLK);
    cmd.round     = (state == S_RND);
    cmd.finish    = (state == S_FIN);
    cmd.reduce    = (state == S_RED);
  end

  // Hold state and registered strobes
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      blk   <= 2'd0;
      busy  <= 1'b0;
      done  <= 1'b0;
      skip  <= 1'b0;
    end else begin
      done <= 1'b0;
      skip <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            if (hardened) begin
              state <= S_BLK;
              blk   <= 2'd0;
              busy  <= 1'b1;
            end else begin
              done <= 1'b1;
              skip <= 1'b1;
            end
          end
        end
        S_BLK: state <= S_RND;
        S_RND: if (sts.last_round) state <= S_FIN;
        S_FIN: begin
          if (blk == 2'd3) begin
            state <= S_RED;
          end else begin
            blk   <= blk + 2'd1;
            state <= S_BLK;
          end
        end
        S_RED: begin
          state <= S_IDLE;
          busy  <= 1'b0;
          done  <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### hdl/hckd_dp.sv
// ----------------------------------------------------------------------------
// hckd_dp
// Datapath: one SHA-512 round a cycle with a rolling 16-word schedule,
// chaining registers, and the final compare and modular add.
// ----------------------------------------------------------------------------
`default_nettype none
module hckd_dp import hckd_pkg::*; (
  input  wire logic        clk,
  input  wire hckd_cmd_t   cmd,
  input  wire logic [255:0] key_in,
  input  wire logic [255:0] chain_in,
  input  wire logic [31:0] cn_in,
  input  wire logic        skip,
  output hckd_sts_t        sts,
  output logic [255:0]     derived_key,
  output logic [255:0]     child_chain,
  output logic [1:0]       status
);

  logic [255:0] key, chain;
  logic [31:0]  cn;
  logic [511:0] h, hin, inner;
  logic [63:0]  s [8];
  logic [63:0]  w [16];
  logic [6:0]   rnd;
  logic [1023:0] blk_data;
  logic [63:0]  t1, t2, wn, a15, b2;
  logic [256:0] sum;
  logic [256:0] diff;
  logic [255:0] red;
  logic [255:0] il;

  assign sts.last_round = (rnd == 7'd79);

  // Select message block
  always_comb begin
    case (cmd.blk)
      2'd0: blk_data = {chain ^ {32{8'h36}}, {96{8'h36}}};
      2'd1: blk_data = {8'h00, key, cn, 8'h80, 592'd0, 128'd1320};
      2'd2: blk_data = {chain ^ {32{8'h5c}}, {96{8'h5c}}};
      default: blk_data = {inner, 8'h80, 376'd0, 128'd1536};
    endcase
  end

  // Round logic
  always_comb begin
    t1 = s[7] + (rotr(s[4], 14) ^ rotr(s[4], 18) ^ rotr(s[4], 41))
       + ((s[4] & s[5]) ^ (~s[4] & s[6])) + round_k(rnd) + w[0];
    t2 = (rotr(s[0], 28) ^ rotr(s[0], 34) ^ rotr(s[0], 39))
       + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
    a15 = w[1];
    b2  = w[14];
    wn = w[0] + (rotr(a15, 1) ^ rotr(a15, 8) ^ (a15 >> 7)) + w[9]
       + (rotr(b2, 19) ^ rotr(b2, 61) ^ (b2 >> 6));
  end

  // Advance compression state
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key   <= key_in;
      chain <= chain_in;
      cn    <= cn_in;
    end
    if (cmd.blk_start) begin
      for (int i = 0; i < 16; i++) w[i] <= blk_data[1023 - 64*i -: 64];
      for (int i = 0; i < 8; i++) s[i] <= hin[511 - 64*i -: 64];
      rnd <= 7'd0;
    end
    if (cmd.round) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wn;
      s[7] <= s[6]; s[6] <= s[5]; s[5] <= s[4]; s[4] <= s[3] + t1;
      s[3] <= s[2]; s[2] <= s[1]; s[1] <= s[0]; s[0] <= t1 + t2;
      rnd <= rnd + 7'd1;
    end
    if (cmd.finish) begin
      for (int i = 0; i < 8; i++) h[511 - 64*i -: 64] <= hin[511 - 64*i -: 64] + s[i];
      if (cmd.blk == 2'd1)
        for (int i = 0; i < 8; i++) inner[511 - 64*i -: 64] <= hin[511 - 64*i -: 64] + s[i];
    end
    // Output registers
    if (skip) begin
      derived_key <= '0;
      child_chain <= '0;
      status      <= ST_NOT_HRD;
    end else if (cmd.reduce) begin
      if (il >= ORDER) begin
        derived_key <= '0; child_chain <= '0; status <= ST_IL_BIG;
      end else if (red == '0) begin
        derived_key <= '0; child_chain <= '0; status <= ST_ZERO;
      end else begin
        derived_key <= red; child_chain <= h[255:0]; status <= ST_OK;
      end
    end
  end

  // Chaining input: IV at the first block of each hash
  assign hin = (cmd.blk == 2'd0 || cmd.blk == 2'd2) ? SHA_IV : h;

  // Modular add of left half and parent key
  always_comb begin
    il   = h[511:256];
    sum  = {1'b0, il} + {1'b0, key};
    diff = sum - {1'b0, ORDER};
    red  = (sum >= {1'b0, ORDER}) ? diff[255:0] : sum[255:0];
  end

endmodule
`default_nettype wire

### hdl/hardened_child_key_derive.sv
// ----------------------------------------------------------------------------
// hardened_child_key_derive
// Hardened child private key derivation with HMAC-SHA512 over secp256k1.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy low. A hardened request
// runs four SHA-512 compressions of 80 rounds on one round unit, each with a
// block load and a finish step, then a reduction step; busy stays high
// throughout, and done pulses for one cycle with the result as busy falls. A
// non-hardened request answers the cycle after with status 1 and busy stays
// low. The result must be taken in the done cycle.
`default_nettype none
module hardened_child_key_derive import hckd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  output logic             done,
  input  wire logic [63:0] parent_key_w0,
  input  wire logic [63:0] parent_key_w1,
  input  wire logic [63:0] parent_key_w2,
  input  wire logic [63:0] parent_key_w3,
  input  wire logic [63:0] parent_chain_w0,
  input  wire logic [63:0] parent_chain_w1,
  input  wire logic [63:0] parent_chain_w2,
  input  wire logic [63:0] parent_chain_w3,
  input  wire logic [31:0] child_number,
  output logic [63:0]      child_key_w0,
  output logic [63:0]      child_key_w1,
  output logic [63:0]      child_key_w2,
  output logic [63:0]      child_key_w3,
  output logic [63:0]      child_chain_w0,
  output logic [63:0]      child_chain_w1,
  output logic [63:0]      child_chain_w2,
  output logic [63:0]      child_chain_w3,
  output logic [1:0]       status
);

  hckd_cmd_t cmd;
  hckd_sts_t sts;
  logic skip, skip_now;
  logic [255:0] ck, cc;

  // Flag a non-hardened request on acceptance
  assign skip_now = start && !busy && !child_number[31];

  hckd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .hardened(child_number[31]),
    .sts(sts), .cmd(cmd), .busy(busy), .done(done), .skip(skip)
  );

  hckd_dp u_dp (
    .clk(clk), .cmd(cmd),
    .key_in({parent_key_w0, parent_key_w1, parent_key_w2, parent_key_w3}),
    .chain_in({parent_chain_w0, parent_chain_w1, parent_chain_w2, parent_chain_w3}),
    .cn_in(child_number), .skip(skip_now), .sts(sts),
    .derived_key(ck), .child_chain(cc), .status(status)
  );

  assign child_key_w0 = ck[255:192];
  assign child_key_w1 = ck[191:128];
  assign child_key_w2 = ck[127:64];
  assign child_key_w3 = ck[63:0];
  assign child_chain_w0 = cc[255:192];
  assign child_chain_w1 = cc[191:128];
  assign child_chain_w2 = cc[127:64];
  assign child_chain_w3 = cc[63:0];

  // Checks
  a_skip_done: assert property (@(posedge clk) disable iff (rst) skip |-> done)
    else $error("skip without done");
  a_skip_status: assert property (@(posedge clk) disable iff (rst)
    skip |-> status == ST_NOT_HRD) else $error("bad status on skip");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (ck == '0 && cc == '0))
    else $error("data not cleared on error");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");

endmodule
`default_nettype wire
